// File: rtl/swd_host_transfer_engine_assert.svh
// assertion macros for the swd host transfer engine
`ifndef SWD_HOST_TRANSFER_ENGINE_ASSERT_SVH
`define SWD_HOST_TRANSFER_ENGINE_ASSERT_SVH

`ifndef SYNTH
`define SWD_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("swd assertion failed");
`define SWD_ASSERT_NEXT(label, clk, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("swd assertion failed");
`else
`define SWD_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define SWD_ASSERT_NEXT(label, clk, cond, expr)
`endif

`endif

// File: rtl/swd_pkg.sv
// shared types and constants of the swd host transfer engine
package swd_pkg;

  // default sequence lengths and queue depth
  localparam int LINE_RESET_CLOCKS_DEF = 60;
  localparam int IDLE_CLOCKS_DEF       = 8;
  localparam int QUEUE_DEPTH_DEF       = 2;

  // line sequence constants
  localparam logic [15:0] SWITCH_WORD = 16'hE79E;
  localparam int          SWITCH_BITS = 16;
  localparam int          DATA_BITS   = 32;
  localparam int          REQ_BITS    = 8;
  localparam int          ACK_BITS    = 3;
  localparam logic [2:0]  ACK_OK      = 3'd1;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // item kinds carried in tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // classified request from the front end to the engine
  typedef struct packed {
    logic        is_tick;
    logic [7:0]  request_byte;
    logic        read_flag;
    logic [31:0] wr_word;
    logic        swdio_in;
  } cmd_t;

  // one clock's result
  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        done_res;
    logic [2:0]  ack;
    logic        parity_error;
    logic [31:0] rd_word;
  } res_t;

endpackage

// File: rtl/swd_host_transfer_engine.sv
// Top level of the SWD host transfer engine: one input item per serial clock tick.
// A tick item's result passes through the queue and then the result register before it leaves.
// Throughput: one item per cycle while the result side takes results, set by the sequencer step in the engine.
// A start item gives no result; a tick while idle gives none either.
// Reset (synchronous, active high) empties the queue and returns the sequencer to idle.
module swd_host_transfer_engine #(
  parameter int LINE_RESET_CLOCKS = swd_pkg::LINE_RESET_CLOCKS_DEF,
  parameter int IDLE_CLOCKS       = swd_pkg::IDLE_CLOCKS_DEF,
  parameter int QUEUE_DEPTH       = swd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // bit 0 port_select, 2:1 reg_addr, 3 is_read, 35:4 wr_word, 36 swdio_in
  input  logic [swd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // bit 0 operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bit 0 swdio_out, 1 swdio_drive, 4:2 ack, 5 parity_error, 37:6 rd_word
  output logic [swd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // done_res
  output logic                              m_axis_tlast
);

  localparam int MaxCount = (LINE_RESET_CLOCKS > swd_pkg::DATA_BITS) ?
                            ((LINE_RESET_CLOCKS > IDLE_CLOCKS) ? LINE_RESET_CLOCKS : IDLE_CLOCKS) :
                            ((swd_pkg::DATA_BITS > IDLE_CLOCKS) ? swd_pkg::DATA_BITS : IDLE_CLOCKS);
  localparam int BitCountW = $clog2(MaxCount + 1);

  logic          queue_full;
  logic          push;
  swd_pkg::cmd_t push_cmd;
  logic          head_valid;
  swd_pkg::cmd_t head_cmd;
  logic          cmd_ready;
  swd_pkg::res_t res;

  // classify incoming items
  swd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // decoupling queue
  swd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop_ready  (cmd_ready)
  );

  // line sequencer
  swd_back #(
    .LINE_RESET_CLOCKS (LINE_RESET_CLOCKS),
    .IDLE_CLOCKS       (IDLE_CLOCKS),
    .BCW               (BitCountW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_ready (cmd_ready),
    .res_valid (m_axis_tvalid),
    .res       (res),
    .res_ready (m_axis_tready)
  );

  // result packing
  assign m_axis_tdata = {2'b00, res.rd_word, res.parity_error, res.ack,
                         res.swdio_drive, res.swdio_out};
  assign m_axis_tlast = res.done_res;

  `include "swd_host_transfer_engine_assert.svh"

  // released line reads as low
  `SWD_ASSERT_IMPLIES(a_released_low, clk, rst, m_axis_tvalid && !m_axis_tdata[1], !m_axis_tdata[0])
  // result fields stay clear before the final clock
  `SWD_ASSERT_IMPLIES(a_fields_clear, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[37:2] == '0)
  // the final clock is always driven by the host
  `SWD_ASSERT_IMPLIES(a_last_driven, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1])
  // reset leaves no pending result
  `SWD_ASSERT_NEXT(a_reset_empty, clk, rst, !m_axis_tvalid)

endmodule

// File: rtl/swd_queue.sv
// short request queue between the front end and the engine
module swd_queue #(
  parameter int DEPTH = swd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  swd_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output swd_pkg::cmd_t head_cmd,
  input  logic          pop_ready
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  swd_pkg::cmd_t entries [DEPTH];
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] tail;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  // status and handshakes
  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[head];
  assign do_push    = push && !full;
  assign do_pop     = head_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PtrW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PtrW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/swd_front.sv
// front end: takes stream items and classifies them into engine requests
module swd_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // bit 0 port_select, 2:1 reg_addr, 3 is_read, 35:4 wr_word, 36 swdio_in
  input  logic [swd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // bit 0 operation
  input  logic                             s_axis_tuser,
  input  logic                             queue_full,
  output logic                             push,
  output swd_pkg::cmd_t                    push_cmd
);

  logic       port_select;
  logic [1:0] reg_addr;
  logic       is_read;
  logic       req_parity;

  // field unpacking
  assign port_select = s_axis_tdata[0];
  assign reg_addr    = s_axis_tdata[2:1];
  assign is_read     = s_axis_tdata[3];

  // even parity over APnDP, RnW, A2, A3
  assign req_parity = port_select ^ is_read ^ reg_addr[0] ^ reg_addr[1];

  // request byte: start, APnDP, RnW, A2, A3, parity, stop, park
  always_comb begin
    push_cmd              = '0;
    push_cmd.is_tick      = (s_axis_tuser == swd_pkg::OP_TICK);
    push_cmd.request_byte = {1'b1, 1'b0, req_parity, reg_addr[1], reg_addr[0],
                             is_read, port_select, 1'b1};
    push_cmd.read_flag    = is_read;
    push_cmd.wr_word      = s_axis_tdata[35:4];
    push_cmd.swdio_in     = s_axis_tdata[36];
  end

  // handshake
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

endmodule

// File: rtl/swd_back.sv
// engine: steps the swd line sequence one serial clock per request
module swd_back #(
  parameter int LINE_RESET_CLOCKS = swd_pkg::LINE_RESET_CLOCKS_DEF,
  parameter int IDLE_CLOCKS       = swd_pkg::IDLE_CLOCKS_DEF,
  parameter int BCW               = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  swd_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          res_valid,
  output swd_pkg::res_t res,
  input  logic          res_ready
);

  // phase codes
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_LRESET = 4'd1;
  localparam logic [3:0] PH_SWITCH = 4'd2;
  localparam logic [3:0] PH_IDLEC  = 4'd3;
  localparam logic [3:0] PH_REQ    = 4'd4;
  localparam logic [3:0] PH_TURN   = 4'd5;
  localparam logic [3:0] PH_ACK    = 4'd6;
  localparam logic [3:0] PH_RDATA  = 4'd7;
  localparam logic [3:0] PH_RPAR   = 4'd8;
  localparam logic [3:0] PH_WTURN  = 4'd9;
  localparam logic [3:0] PH_WDATA  = 4'd10;
  localparam logic [3:0] PH_WPAR   = 4'd11;
  localparam logic [3:0] PH_FINAL  = 4'd12;

  logic [3:0]     phase,        phase_next;
  logic [BCW-1:0] bit_count,    bit_count_next;
  logic [31:0]    shift_word,   shift_word_next;
  logic           parity_acc,   parity_acc_next;
  logic [7:0]     request_byte, request_byte_next;
  logic           read_flag,    read_flag_next;
  logic [2:0]     ack_reg,      ack_reg_next;
  logic           out_valid_next;
  swd_pkg::res_t  step_res;
  logic           step_has_res;
  logic           busy;
  logic           pop;
  logic [BCW-1:0] cnt_inc;

  assign busy      = (phase >= PH_LRESET) && (phase <= PH_FINAL);
  assign cmd_ready = !res_valid || res_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cnt_inc   = bit_count + 1'b1;

  // one serial clock of the sequence
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_word_next   = shift_word;
    parity_acc_next   = parity_acc;
    request_byte_next = request_byte;
    read_flag_next    = read_flag;
    ack_reg_next      = ack_reg;
    step_res          = '0;
    step_has_res      = 1'b0;
    if (pop) begin
      if (!cmd.is_tick) begin
        // latch a new transfer when idle
        if (!busy) begin
          request_byte_next = cmd.request_byte;
          read_flag_next    = cmd.read_flag;
          shift_word_next   = cmd.wr_word;
          parity_acc_next   = 1'b0;
          ack_reg_next      = '0;
          phase_next        = PH_LRESET;
          bit_count_next    = '0;
        end
      end else if (!busy) begin
        phase_next = PH_IDLE;
      end else begin
        step_has_res   = 1'b1;
        bit_count_next = cnt_inc;
        case (phase)
          PH_LRESET: begin
            step_res.swdio_out   = 1'b1;
            step_res.swdio_drive = 1'b1;
            if (cnt_inc == BCW'(LINE_RESET_CLOCKS)) begin
              phase_next     = PH_SWITCH;
              bit_count_next = '0;
            end
          end
          PH_SWITCH: begin
            step_res.swdio_out   = swd_pkg::SWITCH_WORD[bit_count[3:0]];
            step_res.swdio_drive = 1'b1;
            if (cnt_inc == BCW'(swd_pkg::SWITCH_BITS)) begin
              phase_next     = (IDLE_CLOCKS == 0) ? PH_REQ : PH_IDLEC;
              bit_count_next = '0;
            end
          end
          PH_IDLEC: begin
            step_res.swdio_drive = 1'b1;
            if (cnt_inc == BCW'(IDLE_CLOCKS)) begin
              phase_next     = PH_REQ;
              bit_count_next = '0;
            end
          end
          PH_REQ: begin
            step_res.swdio_out   = request_byte[bit_count[2:0]];
            step_res.swdio_drive = 1'b1;
            if (cnt_inc == BCW'(swd_pkg::REQ_BITS)) begin
              phase_next     = PH_TURN;
              bit_count_next = '0;
            end
          end
          PH_TURN: begin
            phase_next     = PH_ACK;
            bit_count_next = '0;
          end
          PH_ACK: begin
            ack_reg_next = ack_reg;
            ack_reg_next[bit_count[1:0]] = ack_reg[bit_count[1:0]] | cmd.swdio_in;
            if (cnt_inc == BCW'(swd_pkg::ACK_BITS)) begin
              bit_count_next = '0;
              if (ack_reg_next != swd_pkg::ACK_OK) begin
                phase_next = PH_FINAL;
              end else begin
                phase_next = read_flag ? PH_RDATA : PH_WTURN;
              end
            end
          end
          PH_RDATA: begin
            shift_word_next = {cmd.swdio_in, shift_word[31:1]};
            parity_acc_next = parity_acc ^ cmd.swdio_in;
            if (cnt_inc == BCW'(swd_pkg::DATA_BITS)) begin
              phase_next     = PH_RPAR;
              bit_count_next = '0;
            end
          end
          PH_RPAR: begin
            parity_acc_next = parity_acc ^ cmd.swdio_in;
            phase_next      = PH_FINAL;
            bit_count_next  = '0;
          end
          PH_FINAL: begin
            step_res.swdio_out    = 1'b1;
            step_res.swdio_drive  = 1'b1;
            step_res.done_res     = 1'b1;
            step_res.ack          = ack_reg;
            step_res.parity_error = parity_acc;
            if (read_flag && (ack_reg == swd_pkg::ACK_OK) && !parity_acc) begin
              step_res.rd_word = shift_word;
            end
            phase_next     = PH_IDLE;
            bit_count_next = '0;
          end
          PH_WTURN: begin
            parity_acc_next = ^shift_word;
            phase_next      = PH_WDATA;
            bit_count_next  = '0;
          end
          PH_WDATA: begin
            step_res.swdio_out   = shift_word[0];
            step_res.swdio_drive = 1'b1;
            shift_word_next      = {1'b0, shift_word[31:1]};
            if (cnt_inc == BCW'(swd_pkg::DATA_BITS)) begin
              phase_next     = PH_WPAR;
              bit_count_next = '0;
            end
          end
          PH_WPAR: begin
            step_res.swdio_out   = parity_acc;
            step_res.swdio_drive = 1'b1;
            step_res.done_res    = 1'b1;
            step_res.ack         = ack_reg;
            phase_next           = PH_IDLE;
            bit_count_next       = '0;
          end
          default: begin
            step_has_res   = 1'b0;
            phase_next     = PH_IDLE;
            bit_count_next = bit_count;
          end
        endcase
      end
    end
  end

  // output register valid
  assign out_valid_next = (res_valid && !res_ready) || (pop && step_has_res);

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_word   <= '0;
      parity_acc   <= 1'b0;
      request_byte <= '0;
      read_flag    <= 1'b0;
      ack_reg      <= '0;
      res_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_word   <= shift_word_next;
      parity_acc   <= parity_acc_next;
      request_byte <= request_byte_next;
      read_flag    <= read_flag_next;
      ack_reg      <= ack_reg_next;
      res_valid    <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && step_has_res) begin
      res <= step_res;
    end
  end

endmodule

// File: tb/swd_host_transfer_engine_checker.sv
// line predictor and result checker for the swd host transfer engine testbench
module swd_line_checker #(
  parameter int LINE_RESET_CLOCKS = swd_pkg::LINE_RESET_CLOCKS_DEF,
  parameter int IDLE_CLOCKS       = swd_pkg::IDLE_CLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // bit 0 port_select, 2:1 reg_addr, 3 is_read, 35:4 wr_word, 36 swdio_in
  input  logic [swd_pkg::IN_TDATA_W-1:0]  s_tdata,
  // bit 0 operation
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // bit 0 swdio_out, 1 swdio_drive, 4:2 ack, 5 parity_error, 37:6 rd_word
  input  logic [swd_pkg::OUT_TDATA_W-1:0] m_tdata,
  // done_res
  input  logic                            m_tlast,
  output int                              mismatch_count,
  output int                              pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // sequencer phases of the predicted line
  typedef enum logic [3:0] {
    LINE_IDLE,
    LINE_RESET,
    LINE_SWITCH,
    LINE_IDLEC,
    LINE_REQUEST,
    LINE_TURN,
    LINE_ACK,
    LINE_RDATA,
    LINE_RPARITY,
    LINE_WTURN,
    LINE_WDATA,
    LINE_WPARITY,
    LINE_FINAL
  } line_phase_e;

  line_phase_e   phase_q   = LINE_IDLE;
  logic [6:0]    bit_cnt   = '0;
  logic [31:0]   shift_q   = '0;
  logic          par_acc   = 1'b0;
  logic [7:0]    req_byte  = '0;
  logic          rd_flag   = 1'b0;
  logic [2:0]    ack_acc   = '0;
  swd_pkg::res_t expected_line_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
  endtask

  task automatic enter_phase(input line_phase_e p);
    phase_q = p;
    bit_cnt = '0;
  endtask

  // one accepted request: latch a transfer or step the line by one clock
  task automatic advance_line_model(input logic op,
                                    input logic [swd_pkg::IN_TDATA_W-1:0] d);
    swd_pkg::res_t r;
    logic          ps;
    logic          rd;
    logic          sin;
    logic [1:0]    ra;
    logic [31:0]   wd;
    ps  = d[0];
    ra  = d[2:1];
    rd  = d[3];
    wd  = d[35:4];
    sin = d[36];
    // start only takes effect while idle
    if (op == swd_pkg::OP_START) begin
      if (phase_q == LINE_IDLE) begin
        req_byte = {1'b1, 1'b0, ps ^ rd ^ ra[0] ^ ra[1], ra[1], ra[0], rd, ps, 1'b1};
        rd_flag  = rd;
        shift_q  = wd;
        par_acc  = 1'b0;
        ack_acc  = '0;
        enter_phase(LINE_RESET);
      end
      return;
    end
    // tick while idle gives nothing
    if (phase_q == LINE_IDLE) return;
    r = '0;
    case (phase_q)
      LINE_RESET: begin
        r.swdio_out   = 1'b1;
        r.swdio_drive = 1'b1;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= LINE_RESET_CLOCKS) enter_phase(LINE_SWITCH);
      end
      LINE_SWITCH: begin
        r.swdio_out   = swd_pkg::SWITCH_WORD[bit_cnt[3:0]];
        r.swdio_drive = 1'b1;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= swd_pkg::SWITCH_BITS)
          enter_phase(IDLE_CLOCKS == 0 ? LINE_REQUEST : LINE_IDLEC);
      end
      LINE_IDLEC: begin
        r.swdio_drive = 1'b1;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= IDLE_CLOCKS) enter_phase(LINE_REQUEST);
      end
      LINE_REQUEST: begin
        r.swdio_out   = req_byte[bit_cnt[2:0]];
        r.swdio_drive = 1'b1;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= swd_pkg::REQ_BITS) enter_phase(LINE_TURN);
      end
      LINE_TURN: enter_phase(LINE_ACK);
      LINE_ACK: begin
        ack_acc[bit_cnt[1:0]] = ack_acc[bit_cnt[1:0]] | sin;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= swd_pkg::ACK_BITS) begin
          if (ack_acc != swd_pkg::ACK_OK) enter_phase(LINE_FINAL);
          else enter_phase(rd_flag ? LINE_RDATA : LINE_WTURN);
        end
      end
      LINE_RDATA: begin
        shift_q = {sin, shift_q[31:1]};
        par_acc = par_acc ^ sin;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= swd_pkg::DATA_BITS) enter_phase(LINE_RPARITY);
      end
      LINE_RPARITY: begin
        par_acc = par_acc ^ sin;
        enter_phase(LINE_FINAL);
      end
      LINE_FINAL: begin
        r.swdio_out    = 1'b1;
        r.swdio_drive  = 1'b1;
        r.done_res     = 1'b1;
        r.ack          = ack_acc;
        r.parity_error = par_acc;
        if (rd_flag && ack_acc == swd_pkg::ACK_OK && !par_acc) r.rd_word = shift_q;
        enter_phase(LINE_IDLE);
      end
      LINE_WTURN: begin
        par_acc = ^shift_q;
        enter_phase(LINE_WDATA);
      end
      LINE_WDATA: begin
        r.swdio_out   = shift_q[0];
        r.swdio_drive = 1'b1;
        shift_q = shift_q >> 1;
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= swd_pkg::DATA_BITS) enter_phase(LINE_WPARITY);
      end
      default: begin
        r.swdio_out   = par_acc;
        r.swdio_drive = 1'b1;
        r.done_res    = 1'b1;
        r.ack         = ack_acc;
        enter_phase(LINE_IDLE);
      end
    endcase
    expected_line_q.push_back(r);
  endtask

  // compare a delivered clock result with the oldest prediction
  task automatic check_line_result();
    swd_pkg::res_t want;
    if (expected_line_q.size() == 0) begin
      report_mismatch("unexpected result", '0, m_tdata[31:0]);
      return;
    end
    want = expected_line_q.pop_front();
    if (m_tdata[0] !== want.swdio_out)
      report_mismatch("swdio_out", 32'(want.swdio_out), 32'(m_tdata[0]));
    if (m_tdata[1] !== want.swdio_drive)
      report_mismatch("swdio_drive", 32'(want.swdio_drive), 32'(m_tdata[1]));
    if (m_tlast !== want.done_res)
      report_mismatch("done_res", 32'(want.done_res), 32'(m_tlast));
    if (m_tdata[4:2] !== want.ack)
      report_mismatch("ack", 32'(want.ack), 32'(m_tdata[4:2]));
    if (m_tdata[5] !== want.parity_error)
      report_mismatch("parity_error", 32'(want.parity_error), 32'(m_tdata[5]));
    if (m_tdata[37:6] !== want.rd_word)
      report_mismatch("rd_word", want.rd_word, m_tdata[37:6]);
  endtask

  // watch both channels at every rising edge
  always @(posedge clk) begin
    if (rst) begin
      phase_q = LINE_IDLE;
      bit_cnt = '0;
      shift_q = '0;
      par_acc = 1'b0;
      req_byte = '0;
      rd_flag = 1'b0;
      ack_acc = '0;
      expected_line_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_line_result();
      if (s_tvalid && s_tready) advance_line_model(s_tuser, s_tdata);
    end
    pending_results = expected_line_q.size();
  end

endmodule

// File: tb/swd_host_transfer_engine_tb.sv
// stimulus, clocking and verdict for the swd host transfer engine testbench
module swd_host_transfer_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ticks from start of transfer up to the first ack bit
  localparam int TICKS_BEFORE_ACK =
    swd_pkg::LINE_RESET_CLOCKS_DEF + swd_pkg::SWITCH_BITS + swd_pkg::IDLE_CLOCKS_DEF +
    swd_pkg::REQ_BITS + 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT    = 400000;

  // acknowledge code used in place of ok for a failed transfer
  localparam logic [2:0] ACK_WAIT  = 3'd2;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_kind   = swd_pkg::OP_TICK;
  logic [swd_pkg::IN_TDATA_W-1:0]  in_data   = '0;
  logic                            out_ready = 1'b0;
  logic                            s_axis_tready;
  logic                            m_axis_tvalid;
  logic [swd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  int                              mismatch_count;
  int                              pending_results;
  int                              items_sent  = 0;
  int                              cycle_count = 0;
  int                              ready_hold  = 0;
  bit                              gap_enable  = 1'b0;

  always #5 clk = ~clk;

  swd_host_transfer_engine uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_kind),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  swd_line_checker line_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (in_valid),
    .s_tready        (s_axis_tready),
    .s_tdata         (in_data),
    .s_tuser         (in_kind),
    .m_tvalid        (m_axis_tvalid),
    .m_tready        (out_ready),
    .m_tdata         (m_axis_tdata),
    .m_tlast         (m_axis_tlast),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  function automatic int pick_pause();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [swd_pkg::IN_TDATA_W-1:0] pack_fields(
    input logic ps, input logic [1:0] ra, input logic rd, input logic [31:0] wd,
    input logic sin);
    return {{(swd_pkg::IN_TDATA_W-37){1'b0}}, sin, wd, rd, ra, ps};
  endfunction

  function automatic logic [swd_pkg::IN_TDATA_W-1:0] random_item(input logic sin);
    return pack_fields(1'($urandom_range(1, 0)), 2'($urandom_range(3, 0)),
                       1'($urandom_range(1, 0)), $urandom(), sin);
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(input logic op, input logic [swd_pkg::IN_TDATA_W-1:0] d);
    int pause;
    pause = gap_enable ? pick_pause() : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= op;
    in_data  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // one whole transfer: start, then every tick with the target's answer on swdio
  task automatic run_transfer(input logic ps, input logic [1:0] ra, input logic rd,
                              input logic [31:0] wd, input logic [2:0] ack_code,
                              input logic [31:0] rword, input logic bad_parity,
                              input logic noise);
    int   n_ticks;
    int   data_at;
    int   k;
    logic ok;
    logic sin;
    ok      = (ack_code == swd_pkg::ACK_OK);
    data_at = TICKS_BEFORE_ACK + swd_pkg::ACK_BITS;
    n_ticks = data_at + (ok ? swd_pkg::DATA_BITS + 2 : 1);
    // ticks while idle are dropped
    if (noise) repeat ($urandom_range(2, 1))
      send_request(swd_pkg::OP_TICK, random_item(1'($urandom())));
    send_request(swd_pkg::OP_START, pack_fields(ps, ra, rd, wd, 1'($urandom_range(1, 0))));
    for (k = 0; k < n_ticks; k++) begin
      // starts while busy are dropped
      if (noise && $urandom_range(19, 0) == 0)
        send_request(swd_pkg::OP_START, random_item(1'($urandom_range(1, 0))));
      sin = 1'($urandom_range(1, 0));
      if (k >= TICKS_BEFORE_ACK && k < data_at)
        sin = ack_code[k - TICKS_BEFORE_ACK];
      else if (ok && rd && k >= data_at && k < data_at + swd_pkg::DATA_BITS)
        sin = rword[k - data_at];
      else if (ok && rd && k == data_at + swd_pkg::DATA_BITS)
        sin = (^rword) ^ bad_parity;
      send_request(swd_pkg::OP_TICK, random_item(sin));
    end
  endtask

  // result side stalls: short ones mostly, long ready stretches now and then
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold = ($urandom_range(9, 0) < 8) ? $urandom_range(2, 0) : $urandom_range(30, 8);
    end else begin
      out_ready <= 1'b1;
      ready_hold = ($urandom_range(9, 0) < 8) ? $urandom_range(10, 0) : $urandom_range(300, 100);
    end
  end

  // run limit
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("swd_host_transfer_engine verification failed");
    $finish;
  end

  // main sequence
  initial begin
    logic [2:0] ack_code;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // read with all ones data, no gaps
    gap_enable = 1'b0;
    send_request(swd_pkg::OP_TICK, random_item(1'b1));
    run_transfer(1'b0, 2'd0, 1'b1, 32'h0, swd_pkg::ACK_OK, 32'hFFFF_FFFF, 1'b0, 1'b0);
    gap_enable = 1'b1;
    // write with all ones data and stray requests around it
    run_transfer(1'b1, 2'd3, 1'b0, 32'hFFFF_FFFF, swd_pkg::ACK_OK, 32'h0, 1'b0, 1'b1);
    // read with a bad parity bit from the target
    run_transfer(1'b1, 2'd2, 1'b1, 32'hFFFF_FFFF, swd_pkg::ACK_OK, pick_word(), 1'b1, 1'b0);
    // write refused by a random non-ok ack
    ack_code = 3'($urandom_range(7, 0));
    if (ack_code == swd_pkg::ACK_OK) ack_code = ACK_WAIT;
    run_transfer(1'($urandom_range(1, 0)), 2'($urandom_range(3, 0)), 1'b0, pick_word(),
                 ack_code, pick_word(), 1'b0, 1'b1);

    // drain and verdict
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("swd_host_transfer_engine verification clean");
    else
      $display("swd_host_transfer_engine verification failed");
    $finish;
  end

endmodule

// File: swd_host_transfer_engine.f
+incdir+rtl
rtl/swd_pkg.sv
rtl/swd_queue.sv
rtl/swd_front.sv
rtl/swd_back.sv
rtl/swd_host_transfer_engine.sv
tb/swd_host_transfer_engine_checker.sv
tb/swd_host_transfer_engine_tb.sv
